@@ hw/rtl/rti_pkg.sv @@
// Package for the ray/triangle intersection block: widths, register indexes,
// the triangle configuration bundle and the divider pipeline token.
// No dependencies.
package rti_pkg;

  localparam int CoordW   = 20;  // Q10.10 coordinate
  localparam int DiffW    = 21;  // difference of two coordinates
  localparam int ProdW    = 41;  // DiffW x CoordW product
  localparam int MinorW   = 42;  // 2x2 minor
  localparam int WideW    = 64;  // 3x3 determinant terms
  localparam int DivW     = 63;  // divisor and partial remainder
  localparam int QuotW    = 31;  // Q15.16 distance, saturating
  localparam int NLowW    = 15;  // dividend bits shifted in by the divider
  localparam int DivSteps = 31;  // one quotient bit per stage
  localparam int NormW    = 16;
  localparam int MinDistW = 17;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 60;

  localparam logic signed [WideW-1:0] DET_MIN  = 64'sd1073742;
  localparam logic [QuotW-1:0]        DIST_MAX = 31'h7FFF_FFFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_VERTEX_ZERO    = 3'd0,
    REG_VERTEX_ONE     = 3'd1,
    REG_VERTEX_TWO     = 3'd2,
    REG_SURFACE_NORMAL = 3'd3,
    REG_MIN_DISTANCE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CfgDataW-1:0] v0;
    logic [CfgDataW-1:0] v1;
    logic [CfgDataW-1:0] v2;
  } tri_cfg_t;

  typedef struct packed {
    logic             valid;
    logic             miss;
    logic             sat;
    logic [DivW-1:0]  rem;
    logic [DivW-1:0]  dvs;
    logic [NLowW-1:0] nlow;
    logic [QuotW-1:0] quo;
  } div_tok_t;

endpackage

@@ hw/rtl/rti_cramer.sv @@
// Determinant front end: differences, 2x2 minors, 3x3 determinants, sign
// normalization and the hit/miss checks. Six register stages. Uses rti_pkg.
module rti_cramer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [rti_pkg::CoordW-1:0] ox,
  input  logic signed [rti_pkg::CoordW-1:0] oy,
  input  logic signed [rti_pkg::CoordW-1:0] oz,
  input  logic signed [rti_pkg::CoordW-1:0] dx,
  input  logic signed [rti_pkg::CoordW-1:0] dy,
  input  logic signed [rti_pkg::CoordW-1:0] dz,
  input  rti_pkg::tri_cfg_t                tri_cfg,
  output rti_pkg::div_tok_t                tok
);
  import rti_pkg::*;

  // stage 0: differences
  logic signed [DiffW-1:0] a_nxt, b_nxt, d_nxt, e_nxt, f_nxt, h_nxt, i_nxt, j_nxt, l_nxt;
  logic signed [DiffW-1:0] a_r, b_r, d_r, e_r, f_r, h_r, i_r, j_r, l_r;
  logic signed [CoordW-1:0] c_r, g_r, k_r;
  logic v0_r;

  assign a_nxt = {tri_cfg.v0[19], tri_cfg.v0[19:0]}  - {tri_cfg.v1[19], tri_cfg.v1[19:0]};
  assign e_nxt = {tri_cfg.v0[39], tri_cfg.v0[39:20]} - {tri_cfg.v1[39], tri_cfg.v1[39:20]};
  assign i_nxt = {tri_cfg.v0[59], tri_cfg.v0[59:40]} - {tri_cfg.v1[59], tri_cfg.v1[59:40]};
  assign b_nxt = {tri_cfg.v0[19], tri_cfg.v0[19:0]}  - {tri_cfg.v2[19], tri_cfg.v2[19:0]};
  assign f_nxt = {tri_cfg.v0[39], tri_cfg.v0[39:20]} - {tri_cfg.v2[39], tri_cfg.v2[39:20]};
  assign j_nxt = {tri_cfg.v0[59], tri_cfg.v0[59:40]} - {tri_cfg.v2[59], tri_cfg.v2[59:40]};
  assign d_nxt = {tri_cfg.v0[19], tri_cfg.v0[19:0]}  - {ox[CoordW-1], ox};
  assign h_nxt = {tri_cfg.v0[39], tri_cfg.v0[39:20]} - {oy[CoordW-1], oy};
  assign l_nxt = {tri_cfg.v0[59], tri_cfg.v0[59:40]} - {oz[CoordW-1], oz};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt; b_r <= b_nxt; d_r <= d_nxt;
      e_r <= e_nxt; f_r <= f_nxt; h_r <= h_nxt;
      i_r <= i_nxt; j_r <= j_nxt; l_r <= l_nxt;
      c_r <= dx; g_r <= dy; k_r <= dz;
    end
  end

  // stage 1: twelve small products
  logic signed [ProdW-1:0] fk_r, gj_r, gi_r, ek_r, ej_r, fi_r;
  logic signed [ProdW-1:0] gl_r, hk_r, hj_r, fl_r, el_r, hi_r;
  logic signed [DiffW-1:0] a1_r, b1_r, d1_r;
  logic signed [CoordW-1:0] c1_r;
  logic v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fk_r <= f_r * k_r; gj_r <= g_r * j_r;
      gi_r <= g_r * i_r; ek_r <= e_r * k_r;
      ej_r <= e_r * j_r; fi_r <= f_r * i_r;
      gl_r <= g_r * l_r; hk_r <= h_r * k_r;
      hj_r <= h_r * j_r; fl_r <= f_r * l_r;
      el_r <= e_r * l_r; hi_r <= h_r * i_r;
      a1_r <= a_r; b1_r <= b_r; d1_r <= d_r; c1_r <= c_r;
    end
  end

  // stage 2: minors
  logic signed [MinorW-1:0] m1_r, m2_r, m3_r, u1_r, u2_r, u3_r;
  logic signed [DiffW-1:0] a2_r, b2_r, d2_r;
  logic signed [CoordW-1:0] c2_r;
  logic v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= fk_r - gj_r;
      m2_r <= gi_r - ek_r;
      m3_r <= ej_r - fi_r;
      u1_r <= gl_r - hk_r;
      u2_r <= hj_r - fl_r;
      u3_r <= el_r - hi_r;
      a2_r <= a1_r; b2_r <= b1_r; d2_r <= d1_r; c2_r <= c1_r;
    end
  end

  // stage 3: wide products
  logic signed [WideW-1:0] am1_r, bm2_r, cm3_r, dm1_r, bu1_r, cu2_r;
  logic signed [WideW-1:0] au1_r, dm2_r, cu3_r, au2_r, bu3_r, dm3_r;
  logic v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am1_r <= a2_r * m1_r; bm2_r <= b2_r * m2_r; cm3_r <= c2_r * m3_r;
      dm1_r <= d2_r * m1_r; bu1_r <= b2_r * u1_r; cu2_r <= c2_r * u2_r;
      au1_r <= a2_r * u1_r; dm2_r <= d2_r * m2_r; cu3_r <= c2_r * u3_r;
      au2_r <= a2_r * u2_r; bu3_r <= b2_r * u3_r; dm3_r <= d2_r * m3_r;
    end
  end

  // stage 4: determinant and the three numerators
  logic signed [WideW-1:0] det_r, nb_r, ng_r, nt_r;
  logic v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= am1_r + bm2_r + cm3_r;
      nb_r  <= dm1_r + bu1_r + cu2_r;
      ng_r  <= dm2_r + cu3_r - au1_r;
      nt_r  <= dm3_r - au2_r - bu3_r;
    end
  end

  // stage 5: fold the sign into the numerators, check the barycentric range
  logic                    small_det, neg;
  logic signed [WideW-1:0] dabs, nbs, ngs, nts;
  logic signed [WideW:0]   bg_sum;
  logic [DivW-1:0]         num;
  div_tok_t                tok_nxt, tok_r;

  always_comb begin
    small_det = (det_r > -DET_MIN) && (det_r < DET_MIN);
    neg       = det_r[WideW-1];
    dabs      = neg ? -det_r : det_r;
    nbs       = neg ? -nb_r  : nb_r;
    ngs       = neg ? -ng_r  : ng_r;
    nts       = neg ? -nt_r  : nt_r;
    bg_sum    = {nbs[WideW-1], nbs} + {ngs[WideW-1], ngs};
    num       = nts[DivW-1:0];
    tok_nxt.valid = v4_r;
    tok_nxt.miss  = small_det || nbs[WideW-1] || (nbs > dabs) || ngs[WideW-1] ||
                    (ngs > dabs) || (bg_sum > {dabs[WideW-1], dabs}) || nts[WideW-1];
    tok_nxt.dvs   = dabs[DivW-1:0];
    // integer part of t reaches 2^15 exactly when num >> 15 >= det
    tok_nxt.sat   = {{NLowW{1'b0}}, num[DivW-1:NLowW]} >= dabs[DivW-1:0];
    tok_nxt.rem   = {{NLowW{1'b0}}, num[DivW-1:NLowW]};
    tok_nxt.nlow  = num[NLowW-1:0];
    tok_nxt.quo   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok = tok_r;

endmodule

@@ hw/rtl/rti_div_stage.sv @@
// One step of the restoring divider: shift in a dividend bit, compare with
// the divisor, subtract and emit one quotient bit. Uses rti_pkg.
module rti_div_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  rti_pkg::div_tok_t  tok_i,
  output rti_pkg::div_tok_t  tok_o
);
  import rti_pkg::*;

  logic [DivW:0] trial;
  logic          qbit;
  div_tok_t      tok_nxt, tok_r;

  always_comb begin
    trial   = {tok_i.rem, tok_i.nlow[NLowW-1]};
    qbit    = trial >= {1'b0, tok_i.dvs};
    tok_nxt = tok_i;
    tok_nxt.rem  = qbit ? DivW'(trial - {1'b0, tok_i.dvs}) : trial[DivW-1:0];
    tok_nxt.nlow = {tok_i.nlow[NLowW-2:0], 1'b0};
    tok_nxt.quo  = {tok_i.quo[QuotW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

@@ hw/rtl/ray_triangle_intersect.sv @@
// Top level of the ray/triangle intersection unit: configuration registers,
// determinant front end, 31-step divider chain and result register.
// Depends on rti_pkg, rti_cramer and rti_div_stage.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | input     | in_valid / in_stall  | origin_{x,y,z}, direction_{x,y,z}
//  out     | output    | out_valid / out_stall| hit, distance, normal_{x,y,z}
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One item per cycle sustained while no result is held; each item passes 38
// register stages (six of determinant math, one per quotient bit (31) and the
// result register) before out_valid rises. The divider chain makes up most of
// these stages.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults (vertices and normal zero, min distance 66).
// A stalled result freezes the whole pipeline in place, so in_stall follows
// out_stall while a result is held; otherwise every stage advances each cycle.
module ray_triangle_intersect (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rti_pkg::CoordW-1:0]   in_origin_x,
  input  logic signed [rti_pkg::CoordW-1:0]   in_origin_y,
  input  logic signed [rti_pkg::CoordW-1:0]   in_origin_z,
  input  logic signed [rti_pkg::CoordW-1:0]   in_direction_x,
  input  logic signed [rti_pkg::CoordW-1:0]   in_direction_y,
  input  logic signed [rti_pkg::CoordW-1:0]   in_direction_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic [rti_pkg::QuotW-1:0]           out_distance,
  output logic signed [rti_pkg::NormW-1:0]    out_normal_x,
  output logic signed [rti_pkg::NormW-1:0]    out_normal_y,
  output logic signed [rti_pkg::NormW-1:0]    out_normal_z,
  input  logic                                cfg_we,
  input  logic [rti_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [rti_pkg::CfgDataW-1:0]        cfg_data
);
  import rti_pkg::*;

  // Configuration registers; the user must write them only while the pipe is empty; the block does not check.
  tri_cfg_t              tri_r;
  logic [3*NormW-1:0]    normal_r;
  logic [MinDistW-1:0]   min_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tri_r      <= '0;
      normal_r   <= '0;
      min_dist_r <= MinDistW'(66);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_VERTEX_ZERO:    tri_r.v0   <= cfg_data;
        REG_VERTEX_ONE:     tri_r.v1   <= cfg_data;
        REG_VERTEX_TWO:     tri_r.v2   <= cfg_data;
        REG_SURFACE_NORMAL: normal_r   <= cfg_data[3*NormW-1:0];
        REG_MIN_DISTANCE:   min_dist_r <= cfg_data[MinDistW-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Advance everything unless a finished result is waiting to be taken.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  div_tok_t chain [0:DivSteps];

  rti_cramer u_cramer (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .ox       (in_origin_x),
    .oy       (in_origin_y),
    .oz       (in_origin_z),
    .dx       (in_direction_x),
    .dy       (in_direction_y),
    .dz       (in_direction_z),
    .tri_cfg  (tri_r),
    .tok      (chain[0])
  );

  // One quotient bit per stage: 15 integer bits then 16 fraction bits.
  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    rti_div_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tok_i (chain[s]),
      .tok_o (chain[s+1])
    );
  end

  // Result stage: saturate, apply the distance floor, zero a miss.
  div_tok_t             fin;
  logic [QuotW-1:0]     tq;
  logic                 hit_nxt;
  logic                 out_valid_r, out_hit_r;
  logic [QuotW-1:0]     out_distance_r;
  logic [3*NormW-1:0]   out_normal_r;

  assign fin     = chain[DivSteps];
  assign tq      = fin.sat ? DIST_MAX : fin.quo;
  assign hit_nxt = !fin.miss && (tq >= QuotW'(min_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r      <= hit_nxt;
      out_distance_r <= hit_nxt ? tq : '0;
      out_normal_r   <= hit_nxt ? normal_r : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_distance_r;
  assign out_normal_x = out_normal_r[NormW-1:0];
  assign out_normal_y = out_normal_r[2*NormW-1:NormW];
  assign out_normal_z = out_normal_r[3*NormW-1:2*NormW];

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_distance == '0 && out_normal_x == '0 &&
                              out_normal_y == '0 && out_normal_z == '0)
    else $error("miss result carries nonzero payload");
  a_hit_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_distance >= QuotW'(min_dist_r))
    else $error("hit below minimum distance");
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while result held");
`endif

endmodule

@@ tb/ray_triangle_intersect_tb.sv @@
// Self-checking testbench for ray_triangle_intersect: rays against one triangle
// held in the config registers, checked against a built-in integer predictor.
// Depends on rti_pkg and the ray_triangle_intersect RTL.
module ray_triangle_intersect_tb;
  import rti_pkg::*;

  localparam int WatchdogLimit = 4000;  // cycles with no item moving on either side
  localparam int DrainCycles   = 45;    // pipeline latency plus margin
  localparam int LongHold      = 400;   // receiver hold-off that fills the pipeline
  localparam int RandomPhases  = 8;
  localparam int PhaseItems    = 140;
  localparam longint CMax      = 524287;
  localparam longint CMin      = -524288;

  typedef struct packed {
    logic signed [CoordW-1:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct packed {
    logic                    hit;
    logic [QuotW-1:0]        distance;
    logic signed [NormW-1:0] nx, ny, nz;
  } hit_t;

  typedef struct {
    ray_t r;
    bit   miss_known;  // expected result is a plain miss, no prediction needed
  } ray_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CoordW-1:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [CoordW-1:0] in_direction_x = '0, in_direction_y = '0, in_direction_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic [QuotW-1:0] out_distance;
  logic signed [NormW-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Local copy of the triangle registers
  logic [CfgDataW-1:0] tri_v0, tri_v1, tri_v2;
  logic [47:0]         tri_normal;
  logic [MinDistW-1:0] tri_min_dist;

  hit_t expected_hits[$];
  bit   failed = 1'b0;
  int   in_gap_max = 0;
  int   out_gap_max = 0;
  bit   hold_req = 1'b0;
  int   idle_cycles = 0;
  ray_row_t rows[16];

  ray_triangle_intersect u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("ray_triangle_intersect_tb failed");
        $finish;
      end
    end
  end

  function automatic longint coord(logic [CfgDataW-1:0] v, int k);
    logic [CoordW-1:0] c;
    c = v[k*CoordW +: CoordW];
    return longint'($signed(c));
  endfunction

  // Cramer's rule on exact integers; every determinant carries 30 fraction bits.
  function automatic hit_t intersect_ray(ray_t r);
    hit_t   res;
    longint a, b, c, d, e, f, g, h, i, j, k, l;
    longint m1, m2, m3, det, nb, ng, nt, q, rm, tq, frac;
    res = '0;
    a = coord(tri_v0, 0) - coord(tri_v1, 0);
    e = coord(tri_v0, 1) - coord(tri_v1, 1);
    i = coord(tri_v0, 2) - coord(tri_v1, 2);
    b = coord(tri_v0, 0) - coord(tri_v2, 0);
    f = coord(tri_v0, 1) - coord(tri_v2, 1);
    j = coord(tri_v0, 2) - coord(tri_v2, 2);
    d = coord(tri_v0, 0) - longint'(r.ox);
    h = coord(tri_v0, 1) - longint'(r.oy);
    l = coord(tri_v0, 2) - longint'(r.oz);
    c = r.dx; g = r.dy; k = r.dz;
    m1 = f * k - g * j;
    m2 = g * i - e * k;
    m3 = e * j - f * i;
    det = a * m1 + b * m2 + c * m3;
    nb = d * m1 + b * (g * l - h * k) + c * (h * j - f * l);
    ng = a * (h * k - g * l) + d * m2 + c * (e * l - h * i);
    nt = a * (f * l - h * j) + b * (h * i - e * l) + d * m3;
    // near-singular system, zero direction included
    if (det > -longint'(DET_MIN) && det < longint'(DET_MIN)) return res;
    if (det < 0) begin
      det = -det; nb = -nb; ng = -ng; nt = -nt;
    end
    if (nb < 0 || nb > det || ng < 0 || ng > det || nb + ng > det || nt < 0) return res;
    q = nt / det;
    rm = nt % det;
    frac = 0;
    for (int n = 0; n < 16; n++) begin
      rm = rm * 2;
      frac = frac << 1;
      if (rm >= det) begin
        rm = rm - det;
        frac = frac | 1;
      end
    end
    tq = (q >= 32768) ? longint'(DIST_MAX) : ((q << 16) | frac);
    if (tq < longint'(tri_min_dist)) return res;
    res.hit = 1'b1;
    res.distance = tq[QuotW-1:0];
    res.nx = tri_normal[15:0];
    res.ny = tri_normal[31:16];
    res.nz = tri_normal[47:32];
    return res;
  endfunction

  function automatic ray_t mk_ray(longint ox, longint oy, longint oz,
                                  longint dx, longint dy, longint dz);
    ray_t r;
    r.ox = ox[CoordW-1:0]; r.oy = oy[CoordW-1:0]; r.oz = oz[CoordW-1:0];
    r.dx = dx[CoordW-1:0]; r.dy = dy[CoordW-1:0]; r.dz = dz[CoordW-1:0];
    return r;
  endfunction

  function automatic logic [CfgDataW-1:0] pack_vertex(longint x, longint y, longint z);
    return {z[CoordW-1:0], y[CoordW-1:0], x[CoordW-1:0]};
  endfunction

  function automatic longint rand_coord(int span);
    if (span < 0) begin
      // extreme vertices: pick among the two ends of the coordinate range and zero
      case ($urandom_range(0, 2))
        0: return CMax;
        1: return CMin;
        default: return 0;
      endcase
    end
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Aim a ray at a point inside (or just on) the triangle; halve the direction until
  // it can be represented.
  function automatic ray_t aimed_ray();
    longint ox, oy, oz, px, py, pz, dx, dy, dz;
    int     u, v, s;
    u = $urandom_range(0, 256);
    v = $urandom_range(0, 256 - u);
    ox = rand_coord(65536); oy = rand_coord(65536); oz = rand_coord(65536);
    px = coord(tri_v0, 0) + ((coord(tri_v1, 0) - coord(tri_v0, 0)) * u
         + (coord(tri_v2, 0) - coord(tri_v0, 0)) * v) / 256;
    py = coord(tri_v0, 1) + ((coord(tri_v1, 1) - coord(tri_v0, 1)) * u
         + (coord(tri_v2, 1) - coord(tri_v0, 1)) * v) / 256;
    pz = coord(tri_v0, 2) + ((coord(tri_v1, 2) - coord(tri_v0, 2)) * u
         + (coord(tri_v2, 2) - coord(tri_v0, 2)) * v) / 256;
    s = $urandom_range(0, 3);
    dx = (px - ox) >>> s; dy = (py - oy) >>> s; dz = (pz - oz) >>> s;
    while (dx > CMax || dx < CMin || dy > CMax || dy < CMin || dz > CMax || dz < CMin) begin
      dx = dx >>> 1; dy = dy >>> 1; dz = dz >>> 1;
    end
    return mk_ray(ox, oy, oz, dx, dy, dz);
  endfunction

  function automatic ray_t noise_ray();
    logic [127:0] raw;
    ray_t         r;
    raw = {$urandom, $urandom, $urandom, $urandom};
    r = raw[6*CoordW-1:0];
    return r;
  endfunction

  // Write one register; only called while the pipeline is empty.
  task automatic write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_VERTEX_ZERO:    tri_v0 = value;
      REG_VERTEX_ONE:     tri_v1 = value;
      REG_VERTEX_TWO:     tri_v2 = value;
      REG_SURFACE_NORMAL: tri_normal = value[47:0];
      REG_MIN_DISTANCE:   tri_min_dist = value[MinDistW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one item and hold it until accepted; in_valid stays high afterward.
  task automatic send_ray(ray_t r, bit miss_known);
    int gap;
    gap = (in_gap_max > 0) ? $urandom_range(0, in_gap_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_origin_x <= r.ox; in_origin_y <= r.oy; in_origin_z <= r.oz;
    in_direction_x <= r.dx; in_direction_y <= r.dy; in_direction_z <= r.dz;
    do @(posedge clk); while (in_stall);
    expected_hits.push_back(miss_known ? hit_t'('0) : intersect_ray(r));
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic run_rows(int lo, int hi);
    for (int n = lo; n <= hi; n++) send_ray(rows[n].r, rows[n].miss_known);
  endtask

  // Receiver: random stall before each item, plus one long hold on request.
  initial begin
    hit_t exp_res;
    int   n;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        n = LongHold;
        hold_req = 1'b0;
      end else begin
        n = (out_gap_max > 0) ? $urandom_range(0, out_gap_max) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (expected_hits.size() == 0) begin
        $error("result with no item pending: hit %0d distance %0h", out_hit, out_distance);
        failed = 1'b1;
      end else begin
        exp_res = expected_hits.pop_front();
        if (out_hit !== exp_res.hit) begin
          $error("hit: expected %0d, got %0d", exp_res.hit, out_hit);
          failed = 1'b1;
        end
        if (out_distance !== exp_res.distance) begin
          $error("distance: expected %0h, got %0h", exp_res.distance, out_distance);
          failed = 1'b1;
        end
        if (out_normal_x !== exp_res.nx) begin
          $error("normal_x: expected %0d, got %0d", exp_res.nx, out_normal_x);
          failed = 1'b1;
        end
        if (out_normal_y !== exp_res.ny) begin
          $error("normal_y: expected %0d, got %0d", exp_res.ny, out_normal_y);
          failed = 1'b1;
        end
        if (out_normal_z !== exp_res.nz) begin
          $error("normal_z: expected %0d, got %0d", exp_res.nz, out_normal_z);
          failed = 1'b1;
        end
      end
    end
  end

  // Main sequence
  initial begin
    int span;
    tri_v0 = '0; tri_v1 = '0; tri_v2 = '0; tri_normal = '0; tri_min_dist = 17'd66;

    // reset triangle is degenerate: everything misses
    rows[0]  = '{mk_ray(0, 0, 0, 1024, 0, 0), 1'b1};
    rows[1]  = '{mk_ray(CMax, CMax, CMax, CMin, CMin, CMin), 1'b1};
    // unit right triangle in the z = 0 plane
    rows[2]  = '{mk_ray(256, 256, 1024, 0, 0, -1024), 1'b0};    // center, t = 1
    rows[3]  = '{mk_ray(0, 0, 1024, 0, 0, -1024), 1'b0};        // first vertex
    rows[4]  = '{mk_ray(1024, 0, 1024, 0, 0, -1024), 1'b0};     // second vertex
    rows[5]  = '{mk_ray(512, 512, 1024, 0, 0, -1024), 1'b0};    // on hypotenuse
    rows[6]  = '{mk_ray(-10, 256, 1024, 0, 0, -1024), 1'b0};    // beta below zero
    rows[7]  = '{mk_ray(600, 600, 1024, 0, 0, -1024), 1'b0};    // beta + gamma over one
    rows[8]  = '{mk_ray(256, 256, 1024, 1024, 0, 0), 1'b1};     // parallel to plane
    rows[9]  = '{mk_ray(256, 256, 1024, 0, 0, 0), 1'b1};        // zero direction
    rows[10] = '{mk_ray(256, 256, 1024, 0, 0, 1024), 1'b0};     // triangle behind
    rows[11] = '{mk_ray(256, 256, CMax, 0, 0, -1), 1'b0};       // saturating distance
    rows[12] = '{mk_ray(256, 256, 0, 0, 0, -1024), 1'b0};       // t = 0, below minimum
    rows[13] = '{mk_ray(CMin, CMin, CMin, CMax, CMax, CMax), 1'b0};
    rows[14] = '{mk_ray(CMax, CMax, CMax, CMin, CMin, CMin), 1'b0};
    rows[15] = '{mk_ray(256, 256, 0, 0, 0, -1024), 1'b0};       // t = 0 with zero minimum

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_rows(0, 1);
    drain();
    write_reg(REG_VERTEX_ZERO, pack_vertex(0, 0, 0));
    write_reg(REG_VERTEX_ONE, pack_vertex(1024, 0, 0));
    write_reg(REG_VERTEX_TWO, pack_vertex(0, 1024, 0));
    write_reg(REG_SURFACE_NORMAL, 60'({16'sd16384, 16'sd0, 16'sd0}));
    run_rows(2, 14);
    drain();
    write_reg(REG_MIN_DISTANCE, '0);
    run_rows(15, 15);
    drain();

    for (int p = 0; p < RandomPhases; p++) begin
      case (p % 4)
        0: span = 65536;
        1: span = 2048;
        2: span = 64;
        default: span = -1;
      endcase
      write_reg(REG_VERTEX_ZERO,
                pack_vertex(rand_coord(span), rand_coord(span), rand_coord(span)));
      write_reg(REG_VERTEX_ONE,
                pack_vertex(rand_coord(span), rand_coord(span), rand_coord(span)));
      write_reg(REG_VERTEX_TWO,
                pack_vertex(rand_coord(span), rand_coord(span), rand_coord(span)));
      // all ones checks that unused upper bits are dropped
      write_reg(REG_SURFACE_NORMAL, (p == 0) ? '1 : 60'({$urandom, $urandom}));
      case (p % 4)
        0: write_reg(REG_MIN_DISTANCE, '0);
        1: write_reg(REG_MIN_DISTANCE, 60'd65536);
        2: write_reg(REG_MIN_DISTANCE, '1);
        default: write_reg(REG_MIN_DISTANCE, 60'($urandom_range(0, 4096)));
      endcase
      in_gap_max  = (p % 3 == 0) ? 0 : 15;
      out_gap_max = (p % 3 == 1) ? 0 : 15;
      if (p == 2) hold_req = 1'b1;  // receiver holds off while items keep coming
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 4 && n == PhaseItems / 2) begin
          // pause the sender until every pending result is back
          in_valid <= 1'b0;
          while (expected_hits.size() != 0) @(posedge clk);
        end
        send_ray(($urandom_range(0, 9) < 7) ? aimed_ray() : noise_ray(), 1'b0);
      end
      drain();
    end

    if (!failed) begin
      $display("ray_triangle_intersect_tb passed");
    end else begin
      $display("ray_triangle_intersect_tb failed");
    end
    $finish;
  end

endmodule

@@ ray_triangle_intersect.f @@
hw/rtl/rti_pkg.sv
hw/rtl/rti_cramer.sv
hw/rtl/rti_div_stage.sv
hw/rtl/ray_triangle_intersect.sv
tb/ray_triangle_intersect_tb.sv
